### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SIFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication.
`define SIFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

### hdl/sifs_pkg.sv
// ----------------------------------------------------------------------------
// sifs_pkg
// Shared widths, constants, types and helper functions of the sensor fusion
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package sifs_pkg;

    localparam int CHANNEL_BITS = 28;
    localparam int NUM_LANES    = 6;
    localparam int NUM_AXES     = 6;
    localparam int CFG_W        = 16;
    localparam int SCALE_W      = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int AXIS_IDX_W   = 3;
    localparam int OUT_W        = 16;
    localparam int CNT_W        = 17;

    localparam int DIFF_DIVISOR = 125;
    localparam int DIV_SHIFT    = CHANNEL_BITS + 7;
    localparam int RECIP_W      = CHANNEL_BITS + 1;
    localparam longint unsigned DIV_RECIP_L =
        ((64'd1 << DIV_SHIFT) + DIFF_DIVISOR - 1) / DIFF_DIVISOR;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_L);
    localparam int PROD_W       = 2 * CHANNEL_BITS + 2;

    localparam int QW = CHANNEL_BITS - 5;
    localparam int DW = QW + 1;
    localparam int MW = DW + 1;
    localparam int AW = DW + 3;
    localparam int SW = AW + SCALE_W + 1;
    localparam int CMP_W = (QW > CFG_W) ? QW : CFG_W;

    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HONE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd2;

    localparam logic [CFG_W-1:0] DEADBAND_RST    = 16'd20;
    localparam logic [CFG_W-1:0] HONE_PERIOD_RST = 16'd100;
    localparam logic [SCALE_W-1:0] SCALE_RST [NUM_AXES] =
        '{8'd120, 8'd120, 8'd35, 8'd30, 8'd30, 8'd50};

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef logic signed [DW-1:0]    diff_t;
    typedef logic signed [MW-1:0]    mix_t;
    typedef logic signed [AW-1:0]    axis_t;
    typedef logic signed [SW-1:0]    scaled_t;
    typedef logic signed [OUT_W-1:0] out_t;

    typedef struct packed {
        logic take;
        logic step1;
        logic step2;
        logic base_wr;
    } sifs_lane_ctl_t;

    typedef struct packed {
        diff_t d;
        logic  above;
        logic  below;
    } sifs_lane_res_t;

    function automatic axis_t ext_mix(input mix_t x);
        return axis_t'(x);
    endfunction

    // Halving that truncates toward zero.
    function automatic axis_t half_tz(input mix_t x);
        axis_t xe;
        axis_t rnd;
        xe  = axis_t'(x);
        rnd = $signed({{(AW-1){1'b0}}, x[MW-1]});
        return (xe + rnd) >>> 1;
    endfunction

    function automatic out_t sat16(input scaled_t p);
        out_t r;
        if (p > scaled_t'(32767))
        begin
            r = 16'sh7FFF;
        end
        else if (p < -scaled_t'(32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = p[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/sifs_if.sv
// ----------------------------------------------------------------------------
// sifs_if
// Valid/ready channels for coil reading sets and fused axis results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sifs_coil_if import sifs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] coil_a0;
    logic [CHANNEL_BITS-1:0] coil_a1;
    logic [CHANNEL_BITS-1:0] coil_a2;
    logic [CHANNEL_BITS-1:0] coil_a3;
    logic [CHANNEL_BITS-1:0] coil_b0;
    logic [CHANNEL_BITS-1:0] coil_b1;

    modport source (output valid, coil_a0, coil_a1, coil_a2, coil_a3, coil_b0, coil_b1,
                    input ready);
    modport sink (input valid, coil_a0, coil_a1, coil_a2, coil_a3, coil_b0, coil_b1,
                  output ready);
endinterface

interface sifs_axis_if import sifs_pkg::*; ();
    logic valid;
    logic ready;
    out_t axis_x;
    out_t axis_y;
    out_t axis_z;
    out_t axis_rx;
    out_t axis_ry;
    out_t axis_rz;
    logic honing_active;

    modport source (output valid, axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz,
                    honing_active, input ready);
    modport sink (input valid, axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz,
                  honing_active, output ready);
endinterface

`default_nettype wire

### hdl/six_axis_inductive_sensor_fusion.sv
// ----------------------------------------------------------------------------
// six_axis_inductive_sensor_fusion
// Six coil readings per transfer in, six saturated axis values out, with a
// drift-honing baseline.
//
// Usage: coil_in carries one set of six coil readings per transfer; axis_out
// returns x, y, z, rx, ry, rz and the honing flag. Registers are written
// through cfg_wr_en, cfg_index and cfg_data only while the block is idle, a
// rule for the user that the block does not enforce. The first transfer
// after reset only stores the baseline and gives no result. Every later
// transfer gives exactly one result, through lane stages v1 to v3, merge
// stages s4 to s7 and the output register. Six lanes work in parallel; a set
// leaves the last lane stage before the next is accepted, because the
// baseline reload decided there feeds the next set's difference. The later
// mixing, gain and saturation stages hold up to five results in flight.
// Reset restores the register defaults, clears the baseline-loaded flag and
// puts the honing machine in the honed state with the quiet flag set.
// When the receiver stalls, results back up through the merge pipeline and
// coil_in.ready drops once the pipeline is full; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module six_axis_inductive_sensor_fusion import sifs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    sifs_coil_if.sink                 coil_in,
    sifs_axis_if.source               axis_out
);

    logic [CFG_W-1:0]   deadband_reg;
    logic [CFG_W-1:0]   hone_period_reg;
    logic [SCALE_W-1:0] scale_reg [NUM_AXES];

    logic v1_reg, v2_reg, v3_reg, loaded_reg;
    logic accept, lane_ready, reload, first_load;

    sifs_lane_ctl_t          ctl;
    sifs_lane_res_t          res [NUM_LANES];
    logic [CHANNEL_BITS-1:0] coil [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg    <= DEADBAND_RST;
            hone_period_reg <= HONE_PERIOD_RST;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                scale_reg[i] <= SCALE_RST[i];
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEADBAND:
                begin
                    deadband_reg <= cfg_data;
                end
                REG_HONE_PERIOD:
                begin
                    hone_period_reg <= cfg_data;
                end
                default:
                begin
                    scale_reg[AXIS_IDX_W'(cfg_index - REG_SCALE_X)] <= cfg_data[SCALE_W-1:0];
                end
            endcase
        end
    end

    assign coil_in.ready = !v1_reg && !v2_reg && (!v3_reg || lane_ready);
    assign accept        = coil_in.valid && coil_in.ready;
    assign first_load    = v1_reg && !loaded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg && loaded_reg;
            v3_reg <= v2_reg || (v3_reg && !lane_ready);
            if (first_load)
            begin
                loaded_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        ctl.take    = accept;
        ctl.step1   = v1_reg;
        ctl.step2   = v2_reg;
        ctl.base_wr = first_load || reload;
    end

    assign coil[0] = coil_in.coil_a0;
    assign coil[1] = coil_in.coil_a1;
    assign coil[2] = coil_in.coil_a2;
    assign coil[3] = coil_in.coil_a3;
    assign coil[4] = coil_in.coil_b0;
    assign coil[5] = coil_in.coil_b1;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        sifs_lane u_lane
        (
            .clk      (clk),
            .ctl      (ctl),
            .coil     (coil[g]),
            .deadband (deadband_reg),
            .res      (res[g])
        );
    end

    sifs_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .lane_valid  (v3_reg),
        .res         (res),
        .hone_period (hone_period_reg),
        .scale       (scale_reg),
        .lane_ready  (lane_ready),
        .reload      (reload),
        .axis_out    (axis_out)
    );

    `SIFS_ASSERT_IMP(a_one_set_in_lanes, clk, rst_n, 1'b1, $onehot0({v1_reg, v2_reg, v3_reg}))
    `SIFS_ASSERT_IMP(a_reload_from_last_stage, clk, rst_n, reload, v3_reg && lane_ready && loaded_reg)
    `SIFS_ASSERT_IMP(a_no_double_base_write, clk, rst_n, first_load, !reload)
    `SIFS_ASSERT_NEXT(a_accept_fills_lane, clk, rst_n, accept, v1_reg && !v2_reg && !v3_reg)

endmodule

`default_nettype wire

### hdl/sifs_lane.sv
// ----------------------------------------------------------------------------
// sifs_lane
// One coil channel: baseline storage, difference magnitude, division by 125
// through a reciprocal multiply, and deadband comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module sifs_lane import sifs_pkg::*;
(
    input  wire logic                    clk,
    input  wire sifs_lane_ctl_t          ctl,
    input  wire logic [CHANNEL_BITS-1:0] coil,
    input  wire logic [CFG_W-1:0]        deadband,
    output sifs_lane_res_t               res
);

    logic [CHANNEL_BITS-1:0] rd_reg;
    logic [CHANNEL_BITS-1:0] base_reg;
    logic [CHANNEL_BITS-1:0] mag_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_s3_reg;

    logic [CHANNEL_BITS:0]   up;
    logic [CHANNEL_BITS:0]   dn;
    logic [CHANNEL_BITS-1:0] mag_next;
    logic [QW-1:0]           q;
    diff_t                   qs;

    assign up       = {1'b0, base_reg} - {1'b0, rd_reg};
    assign dn       = {1'b0, rd_reg} - {1'b0, base_reg};
    assign mag_next = up[CHANNEL_BITS] ? dn[CHANNEL_BITS-1:0] : up[CHANNEL_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            rd_reg <= coil;
        end
        if (ctl.base_wr)
        begin
            base_reg <= rd_reg;
        end
        if (ctl.step1)
        begin
            mag_reg <= mag_next;
            neg_reg <= up[CHANNEL_BITS];
        end
        if (ctl.step2)
        begin
            prod_reg   <= PROD_W'(mag_reg) * PROD_W'(DIV_RECIP);
            neg_s3_reg <= neg_reg;
        end
    end

    assign q  = prod_reg[DIV_SHIFT +: QW];
    assign qs = $signed({1'b0, q});

    always_comb
    begin
        res.d     = neg_s3_reg ? -qs : qs;
        res.above = CMP_W'(q) > CMP_W'(deadband);
        res.below = CMP_W'(q) < CMP_W'(deadband);
    end

endmodule

`default_nettype wire

### hdl/sifs_merge.sv
// ----------------------------------------------------------------------------
// sifs_merge
// Combines the lane results: drift-honing state machine, axis mixing,
// per-axis gain, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sifs_merge import sifs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 lane_valid,
    input  wire sifs_lane_res_t       res [NUM_LANES],
    input  wire logic [CFG_W-1:0]     hone_period,
    input  wire logic [SCALE_W-1:0]   scale [NUM_AXES],
    output logic                      lane_ready,
    output logic                      reload,
    sifs_axis_if.source               axis_out
);

    localparam logic HONED  = 1'b0;
    localparam logic ACTIVE = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             qf_reg, qf_next;

    logic s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg, o_v_reg;
    logic en4, en5, en6, en7, en_o, take;
    logic any_out, all_in;

    diff_t   d4_reg [NUM_LANES];
    logic    qf4_reg, hon4_reg, hon5_reg, hon6_reg, hon7_reg, hon_o_reg;
    mix_t    cm_reg [3];
    mix_t    dm_reg [3];
    axis_t   ax_reg [NUM_AXES];
    scaled_t sc_reg [NUM_AXES];
    out_t    out_reg [NUM_AXES];
    axis_t   ax_next [NUM_AXES];

    assign en_o       = !o_v_reg || axis_out.ready;
    assign en7        = !s7_v_reg || en_o;
    assign en6        = !s6_v_reg || en7;
    assign en5        = !s5_v_reg || en6;
    assign en4        = !s4_v_reg || en5;
    assign lane_ready = en4;
    assign take       = lane_valid && en4;

    always_comb
    begin
        any_out = 1'b0;
        all_in  = 1'b1;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            any_out = any_out | res[i].above;
            all_in  = all_in & res[i].below;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        qf_next    = qf_reg;
        reload     = 1'b0;
        if (take)
        begin
            case (state_reg)
                HONED:
                begin
                    if (any_out)
                    begin
                        state_next = ACTIVE;
                    end
                end
                ACTIVE:
                begin
                    if (all_in)
                    begin
                        cnt_next = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
                        qf_next  = 1'b1;
                    end
                    else
                    begin
                        cnt_next = '0;
                        qf_next  = 1'b0;
                    end
                    if (cnt_next > {1'b0, hone_period})
                    begin
                        reload     = 1'b1;
                        cnt_next   = '0;
                        state_next = HONED;
                    end
                end
                default:
                begin
                    state_next = HONED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HONED;
            cnt_reg   <= '0;
            qf_reg    <= 1'b1;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            o_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            qf_reg    <= qf_next;
            if (en4)
            begin
                s4_v_reg <= lane_valid;
            end
            if (en5)
            begin
                s5_v_reg <= s4_v_reg;
            end
            if (en6)
            begin
                s6_v_reg <= s5_v_reg;
            end
            if (en7)
            begin
                s7_v_reg <= s6_v_reg;
            end
            if (en_o)
            begin
                o_v_reg <= s7_v_reg;
            end
        end
    end

    always_comb
    begin
        ax_next[0] = half_tz(dm_reg[0]) - ext_mix(dm_reg[1]) + half_tz(dm_reg[2]);
        ax_next[1] = ext_mix(dm_reg[2]) - ext_mix(dm_reg[0]);
        ax_next[2] = ext_mix(cm_reg[0]) + ext_mix(cm_reg[1]) + ext_mix(cm_reg[2]);
        ax_next[3] = half_tz(cm_reg[0]) - ext_mix(cm_reg[1]) + half_tz(cm_reg[2]);
        ax_next[4] = ext_mix(cm_reg[2]) - ext_mix(cm_reg[0]);
        ax_next[5] = ext_mix(dm_reg[0]) + ext_mix(dm_reg[1]) + ext_mix(dm_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                d4_reg[i] <= res[i].d;
            end
            qf4_reg  <= qf_next;
            hon4_reg <= (state_next == ACTIVE);
        end
        if (en5 && s4_v_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cm_reg[k] <= qf4_reg ? '0 : mix_t'(d4_reg[2*k]) + mix_t'(d4_reg[2*k+1]);
                dm_reg[k] <= qf4_reg ? '0 : mix_t'(d4_reg[2*k]) - mix_t'(d4_reg[2*k+1]);
            end
            hon5_reg <= hon4_reg;
        end
        if (en6 && s5_v_reg)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                ax_reg[i] <= ax_next[i];
            end
            hon6_reg <= hon5_reg;
        end
        if (en7 && s6_v_reg)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sc_reg[i] <= scaled_t'(ax_reg[i]) * scaled_t'($signed({1'b0, scale[i]}));
            end
            hon7_reg <= hon6_reg;
        end
        if (en_o && s7_v_reg)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                out_reg[i] <= sat16(sc_reg[i]);
            end
            hon_o_reg <= hon7_reg;
        end
    end

    assign axis_out.valid         = o_v_reg;
    assign axis_out.axis_x        = out_reg[0];
    assign axis_out.axis_y        = out_reg[1];
    assign axis_out.axis_z        = out_reg[2];
    assign axis_out.axis_rx       = out_reg[3];
    assign axis_out.axis_ry       = out_reg[4];
    assign axis_out.axis_rz       = out_reg[5];
    assign axis_out.honing_active = hon_o_reg;

endmodule

`default_nettype wire

### sim/sifs_fusion_checker.sv
// ----------------------------------------------------------------------------
// sifs_fusion_checker
// Watches the coil and axis channels and the register port of the sensor
// fusion block. Each accepted coil set goes through a behavioral copy of
// the baseline, honing and mixing logic. Each accepted axis result is
// compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module sifs_fusion_checker import sifs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sifs_coil_if                 coil,
    sifs_axis_if                 axis,
    output int                   fail_count,
    output int                   owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] coil_set_t;

    typedef struct packed {
        out_t [NUM_AXES-1:0] ax;
        logic                honing;
    } fused_t;

    string axis_name [NUM_AXES] = '{"x", "y", "z", "rx", "ry", "rz"};

    logic [CFG_W-1:0]                    deadband;
    logic [CFG_W-1:0]                    hone_period;
    logic [NUM_AXES-1:0][SCALE_W-1:0]    gain;

    coil_set_t        baseline;
    logic             baseline_set;
    logic             honing;
    logic [CNT_W-1:0] quiet_count;
    logic             quiet;

    fused_t fused_q [$];
    int     mismatches;

    // Returns 1 when the set produces a result. Updates the baseline and the
    // honing machine as the block does.
    function automatic logic fuse_coil_set(input coil_set_t rd, output fused_t res);
        longint diff [NUM_LANES];
        longint mix [NUM_AXES];
        longint mag;
        longint v;
        longint cm1, dm1, cm2, dm2, cm3, dm3;
        logic   any_out;
        logic   all_in;
        int     i;
        res = '0;
        if (!baseline_set)
        begin
            baseline     = rd;
            baseline_set = 1'b1;
            return 1'b0;
        end
        any_out = 1'b0;
        all_in  = 1'b1;
        for (i = 0; i < NUM_LANES; i++)
        begin
            diff[i] = (longint'(baseline[i]) - longint'(rd[i])) / DIFF_DIVISOR;
            mag     = (diff[i] < 0) ? -diff[i] : diff[i];
            if (mag > longint'(deadband))
            begin
                any_out = 1'b1;
            end
            if (!(mag < longint'(deadband)))
            begin
                all_in = 1'b0;
            end
        end
        if (!honing)
        begin
            if (any_out)
            begin
                honing = 1'b1;
            end
        end
        else
        begin
            if (all_in)
            begin
                if (quiet_count != COUNT_MAX)
                begin
                    quiet_count = quiet_count + 1'b1;
                end
                quiet = 1'b1;
            end
            else
            begin
                quiet_count = '0;
                quiet       = 1'b0;
            end
            if (quiet_count > CNT_W'(hone_period))
            begin
                baseline    = rd;
                quiet_count = '0;
                honing      = 1'b0;
            end
        end
        cm1 = diff[0] + diff[1];
        dm1 = diff[0] - diff[1];
        cm2 = diff[2] + diff[3];
        dm2 = diff[2] - diff[3];
        cm3 = diff[4] + diff[5];
        dm3 = diff[4] - diff[5];
        mix[0] = -(dm2 - dm1 / 2 - dm3 / 2);
        mix[1] = -dm1 + dm3;
        mix[2] = cm1 + cm2 + cm3;
        mix[3] = cm1 / 2 - cm2 + cm3 / 2;
        mix[4] = -cm1 + cm3;
        mix[5] = dm1 + dm2 + dm3;
        for (i = 0; i < NUM_AXES; i++)
        begin
            v = quiet ? 64'sd0 : mix[i] * longint'(gain[i]);
            if (v > 32767)
            begin
                v = 32767;
            end
            else if (v < -32768)
            begin
                v = -32768;
            end
            res.ax[i] = out_t'(v);
        end
        res.honing = honing;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        coil_set_t rd;
        fused_t    got;
        fused_t    want;
        fused_t    nxt;
        int        i;
        if (!rst_n)
        begin
            deadband     = DEADBAND_RST;
            hone_period  = HONE_PERIOD_RST;
            for (i = 0; i < NUM_AXES; i++)
            begin
                gain[i] = SCALE_RST[i];
            end
            baseline     = '0;
            baseline_set = 1'b0;
            honing       = 1'b0;
            quiet_count  = '0;
            quiet        = 1'b1;
            fused_q.delete();
            mismatches   = 0;
            fail_count  <= 0;
            owed        <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_DEADBAND)
                begin
                    deadband = cfg_data;
                end
                else if (cfg_index == REG_HONE_PERIOD)
                begin
                    hone_period = cfg_data;
                end
                else
                begin
                    gain[cfg_index - REG_SCALE_X] = cfg_data[SCALE_W-1:0];
                end
            end
            if (axis.valid && axis.ready)
            begin
                got.ax[0]  = axis.axis_x;
                got.ax[1]  = axis.axis_y;
                got.ax[2]  = axis.axis_z;
                got.ax[3]  = axis.axis_rx;
                got.ax[4]  = axis.axis_ry;
                got.ax[5]  = axis.axis_rz;
                got.honing = axis.honing_active;
                if (fused_q.size() == 0)
                begin
                    $display("%0t: axis transfer with no result expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = fused_q.pop_front();
                    for (i = 0; i < NUM_AXES; i++)
                    begin
                        if (got.ax[i] !== want.ax[i])
                        begin
                            $display("%0t: axis %s expected %0d, got %0d",
                                     $time, axis_name[i], want.ax[i], got.ax[i]);
                            mismatches++;
                        end
                    end
                    if (got.honing !== want.honing)
                    begin
                        $display("%0t: honing_active expected %0b, got %0b",
                                 $time, want.honing, got.honing);
                        mismatches++;
                    end
                end
            end
            if (coil.valid && coil.ready)
            begin
                rd[0] = coil.coil_a0;
                rd[1] = coil.coil_a1;
                rd[2] = coil.coil_a2;
                rd[3] = coil.coil_a3;
                rd[4] = coil.coil_b0;
                rd[5] = coil.coil_b1;
                if (fuse_coil_set(rd, nxt))
                begin
                    fused_q.push_back(nxt);
                end
            end
            fail_count <= mismatches;
            owed       <= fused_q.size();
        end
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the six-axis inductive sensor fusion block.
// After a short directed run around the baseline, the extremes and the mix
// rounding, it steps through register settings from zero to full scale and
// sends mostly near-baseline coil sets that drive the honing machine through
// activation and baseline reload, mixed with large swings and raw noise.
// Both channel sides idle in random bursts, and once the result side holds
// off long enough to back the block up. A checker module does the prediction.
// ----------------------------------------------------------------------------
module tb_top import sifs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] coil_set_t;

    typedef enum int {
        SET_QUIET,
        SET_EDGE,
        SET_LOUD,
        SET_NOISE
    } set_kind_t;

    localparam int NUM_PHASES      = 9;
    localparam int SETS_PER_PHASE  = 120;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 16;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   owed;

    int        idle_pct;
    bit        long_hold;
    int        cur_db;
    coil_set_t center;

    sifs_coil_if coil ();
    sifs_axis_if axis_res ();

    six_axis_inductive_sensor_fusion uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coil_in   (coil),
        .axis_out  (axis_res)
    );

    sifs_fusion_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coil       (coil),
        .axis       (axis_res),
        .fail_count (fail_count),
        .owed       (owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : result_side
        int stall;
        stall = 0;
        axis_res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                stall     = HOLD_CYCLES;
            end
            else if (stall == 0 && idle_pct > 0 && $urandom_range(0, 299) < idle_pct)
            begin
                stall = $urandom_range(1, 6);
            end
            if (stall > 0)
            begin
                axis_res.ready <= 1'b0;
                stall--;
            end
            else
            begin
                axis_res.ready <= 1'b1;
            end
        end
    end

    task automatic send_set(input coil_set_t s);
        coil.valid   <= 1'b1;
        coil.coil_a0 <= s[0];
        coil.coil_a1 <= s[1];
        coil.coil_a2 <= s[2];
        coil.coil_a3 <= s[3];
        coil.coil_b0 <= s[4];
        coil.coil_b1 <= s[5];
        do
        begin
            @(posedge clk);
        end
        while (!coil.ready);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            coil.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stops sending and lets every owed result and any trailing work finish.
    task automatic settle();
        coil.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] hp,
                              input logic [NUM_AXES-1:0][SCALE_W-1:0] sc);
        int k;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEADBAND;
        cfg_data  <= db;
        @(posedge clk);
        cfg_index <= REG_HONE_PERIOD;
        cfg_data  <= hp;
        @(posedge clk);
        for (k = 0; k < NUM_AXES; k++)
        begin
            cfg_index <= CFG_IDX_W'(REG_SCALE_X + k);
            cfg_data  <= {8'($urandom), sc[k]};
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cur_db = db;
    endtask

    // Readings whose differences against a baseline at the center are exact.
    function automatic coil_set_t offset_set(input int d0, input int d1, input int d2,
                                             input int d3, input int d4, input int d5);
        int        d [NUM_LANES];
        coil_set_t s;
        int        i;
        d = '{d0, d1, d2, d3, d4, d5};
        for (i = 0; i < NUM_LANES; i++)
        begin
            s[i] = CHANNEL_BITS'(longint'(center[i]) - longint'(d[i]) * DIFF_DIVISOR);
        end
        return s;
    endfunction

    function automatic coil_set_t make_set(input set_kind_t kind);
        coil_set_t s;
        longint    lim;
        longint    span;
        longint    off;
        longint    r;
        int        hot;
        int        i;
        lim  = longint'(cur_db) * DIFF_DIVISOR / 3;
        span = (4 * longint'(cur_db) + 200) * DIFF_DIVISOR;
        hot  = $urandom_range(0, NUM_LANES - 1);
        for (i = 0; i < NUM_LANES; i++)
        begin
            off = longint'($urandom_range(0, 32'(2 * lim))) - lim;
            if (kind == SET_EDGE && i == hot)
            begin
                off = (longint'(cur_db) - 1 + $urandom_range(0, 2)) * DIFF_DIVISOR
                      + $urandom_range(0, DIFF_DIVISOR - 1);
                if ($urandom_range(0, 1) == 1)
                begin
                    off = -off;
                end
            end
            else if (kind == SET_LOUD && $urandom_range(0, 1) == 1)
            begin
                off = longint'($urandom_range(0, 32'(2 * span))) - span;
            end
            r = longint'(center[i]) - off;
            if (r < 0)
            begin
                r = 0;
            end
            else if (r > (64'sd1 << CHANNEL_BITS) - 1)
            begin
                r = (64'sd1 << CHANNEL_BITS) - 1;
            end
            s[i] = CHANNEL_BITS'(r);
            if (kind == SET_NOISE)
            begin
                s[i] = CHANNEL_BITS'($urandom);
            end
        end
        return s;
    endfunction

    initial
    begin : stimulus
        int                               p;
        int                               n;
        int                               i;
        int                               roll;
        set_kind_t                        kind;
        coil_set_t                        s;
        logic [CFG_W-1:0]                 db;
        logic [CFG_W-1:0]                 hp;
        logic [NUM_AXES-1:0][SCALE_W-1:0] sc;

        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        coil.valid   <= 1'b0;
        coil.coil_a0 <= '0;
        coil.coil_a1 <= '0;
        coil.coil_a2 <= '0;
        coil.coil_a3 <= '0;
        coil.coil_b0 <= '0;
        coil.coil_b1 <= '0;
        idle_pct  = 0;
        long_hold = 1'b0;
        cur_db    = DEADBAND_RST;
        for (i = 0; i < NUM_LANES; i++)
        begin
            center[i] = CHANNEL_BITS'($urandom_range(1 << 25, (1 << 28) - (1 << 25)));
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed run under the reset register values.
        idle_pct = 25;
        send_set(center);
        send_set(offset_set(0, 0, 0, 0, 0, 0));
        send_set(offset_set(3, -4, 5, -6, 19, -19));
        send_set(offset_set(20, -20, 20, -20, 20, -20));
        send_set('0);
        send_set('1);
        send_set('0);
        send_set(offset_set(25, 0, 0, 0, -1, 0));
        send_set(offset_set(-25, 0, 0, 0, 1, 0));
        send_set(offset_set(0, -25, 3, 0, 0, -3));
        send_set(offset_set(21, 20, 19, -20, -21, 0));
        send_set(offset_set(20, 20, -20, -20, 20, -20));
        send_set(offset_set(19, -19, 1, -1, 7, 0));
        send_set(offset_set(-21, 1, 1, 1, 1, 1));
        s    = '0;
        s[1] = '1;
        s[3] = '1;
        s[4] = '1;
        send_set(s);
        send_set(offset_set(101, -37, 55, -73, 29, -91));
        send_set(offset_set(-101, 37, -55, 73, -29, 91));

        for (p = 0; p < NUM_PHASES; p++)
        begin
            for (i = 0; i < NUM_AXES; i++)
            begin
                sc[i] = SCALE_W'($urandom);
            end
            case (p)
                0:
                begin
                    db = 16'd20;
                    hp = 16'd3;
                    idle_pct = 30;
                end
                1:
                begin
                    db = 16'd0;
                    hp = 16'd0;
                    sc = '1;
                    idle_pct = 0;
                end
                2:
                begin
                    db = 16'hFFFF;
                    hp = 16'hFFFF;
                    sc = '0;
                    idle_pct = 50;
                end
                3:
                begin
                    db = 16'd5;
                    hp = 16'd0;
                    idle_pct = 20;
                end
                4:
                begin
                    db = 16'd1;
                    hp = 16'd1;
                    for (i = 0; i < NUM_AXES; i++)
                    begin
                        sc[i] = SCALE_RST[i];
                    end
                    idle_pct = 40;
                end
                5:
                begin
                    db = 16'd300;
                    hp = 16'd10;
                    idle_pct = 20;
                end
                6:
                begin
                    db = 16'hFFFF;
                    hp = 16'd0;
                    idle_pct = 30;
                end
                7:
                begin
                    db = CFG_W'($urandom_range(0, 60));
                    hp = CFG_W'($urandom_range(0, 12));
                    idle_pct = 30;
                end
                default:
                begin
                    db = CFG_W'($urandom_range(0, 40));
                    hp = CFG_W'($urandom_range(0, 6));
                    idle_pct = 0;
                end
            endcase
            settle();
            write_regs(db, hp, sc);
            for (n = 0; n < SETS_PER_PHASE; n++)
            begin
                if (p == 5 && n == 10)
                begin
                    long_hold = 1'b1;
                end
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    kind = SET_QUIET;
                end
                else if (roll < 72)
                begin
                    kind = SET_EDGE;
                end
                else if (roll < 92)
                begin
                    kind = SET_LOUD;
                end
                else
                begin
                    kind = SET_NOISE;
                end
                send_set(make_set(kind));
            end
        end

        settle();
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
